[hw/rtl/assert_macros.svh]
// assertion helpers for the stack engine checker
// expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property, sampled on the rising edge, off during reset
`define SAE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication
`define SAE_ASSERT_IMPL(label, ante, cons, msg) \
  `SAE_ASSERT(label, (ante) |-> (cons), msg)

`endif

[hw/rtl/sae_pkg.sv]
package sae_pkg;

  localparam int DATA_W          = 32;
  localparam int ACT_W           = 3;
  localparam int DEPTH_OUT_W     = 7;
  localparam int SAE_STACK_DEPTH = 64;

  // request operation codes
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_SWAP = 3'd3,
    ACT_MUL  = 3'd4,
    ACT_MOD  = 3'd5
  } action_t;

  // error codes reported with each result
  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_SHORT   = 2'd1,
    ERR_DIVZERO = 2'd2,
    ERR_FULL    = 2'd3
  } err_t;

  // what a stack cell does on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_DOWN = 2'd1,
    CELL_UP   = 2'd2
  } cell_mode_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_EXEC  = 3'd1,
    ST_DIV   = 3'd2,
    ST_WRITE = 3'd3,
    ST_DONE  = 3'd4
  } state_t;

endpackage

[hw/rtl/sae_cell.sv]
module sae_cell
  import sae_pkg::*;
(
  input  logic              clk,
  input  cell_mode_t        mode_i,
  input  logic [DATA_W-1:0] prev_i,
  input  logic [DATA_W-1:0] next_i,
  output logic [DATA_W-1:0] value_o
);

  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;

  // down takes the entry nearer the top, up the entry nearer the bottom
  always_comb begin
    unique case (mode_i)
      CELL_DOWN: value_nxt = prev_i;
      CELL_UP:   value_nxt = next_i;
      default:   value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o = value_r;

endmodule

[hw/rtl/sae_rem_div.sv]
module sae_rem_div
  import sae_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic              neg_r;
  logic [DATA_W-1:0] dvd_r;
  logic [DATA_W-1:0] dsr_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] shifted;
  logic [DATA_W:0]   trial;

  // one restoring step on magnitudes
  assign shifted = {rem_r[DATA_W-2:0], dvd_r[DATA_W-1]};
  assign trial   = {1'b0, shifted} - {1'b0, dsr_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        cnt_r <= CNT_W'(DATA_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start_i) begin
      neg_r <= dividend_i[DATA_W-1];
      dvd_r <= dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      dsr_r <= divisor_i[DATA_W-1] ? (~divisor_i + 1'b1) : divisor_i;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DATA_W-2:0], 1'b0};
      rem_r <= trial[DATA_W] ? shifted : trial[DATA_W-1:0];
    end
  end

  // sign of the remainder follows the dividend
  assign rem_o  = neg_r ? (~rem_r + 1'b1) : rem_r;
  assign done_o = done_r;

endmodule

[hw/rtl/stack_alu_engine_top.sv]
// channel | ports                                   | direction
// in      | in_valid in_ready in_action in_push_value | request in
// out     | out_valid out_ready out_top_value         | result out
//         | out_stack_depth out_error_code          |
// one request at a time: push, add, sub, swap and mul pass exec, write and
// done; mod with a valid divisor also waits in div for the 32-step remainder
// unit; a new request is taken while the last result still waits
// rst_n clears the sequencer, entry count and valid flags; cell contents
// are left as they were; a stalled result holds until out_ready
module stack_alu_engine_top
  import sae_pkg::*;
#(
  parameter int STACK_DEPTH = SAE_STACK_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ACT_W-1:0]              in_action,
  input  logic signed [DATA_W-1:0]      in_push_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_W-1:0]      out_top_value,
  output logic [DEPTH_OUT_W-1:0]        out_stack_depth,
  output logic [1:0]                    out_error_code
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  state_t            state_r, state_nxt;
  logic [ACT_W-1:0]  act_r;
  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] res_r;
  err_t              err_r;
  err_t              err_nxt;
  logic              wr_r;
  logic              wr_nxt;
  logic [CNT_W-1:0]  count_r;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_rem;
  logic [DATA_W-1:0] alu_res;
  logic [2*DATA_W-1:0] product;
  logic              out_free;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_top_r;
  logic [DEPTH_OUT_W-1:0] out_depth_r;
  err_t              out_err_r;
  logic [CNT_W+DEPTH_OUT_W-1:0] count_ext;

  logic [DATA_W-1:0] cell_q [STACK_DEPTH];
  cell_mode_t        cell_mode [STACK_DEPTH];

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // chain of stack cells, cell 0 is the top of the stack
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] prev_val;
    logic [DATA_W-1:0] next_val;
    if (g == 0) begin : g_top
      assign prev_val = res_r;
    end else begin : g_mid
      assign prev_val = cell_q[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_last
      assign next_val = cell_q[g];
    end else begin : g_inner
      assign next_val = cell_q[g+1];
    end
    sae_cell u_cell (
      .clk     (clk),
      .mode_i  (cell_mode[g]),
      .prev_i  (prev_val),
      .next_i  (next_val),
      .value_o (cell_q[g])
    );
  end

  // shift pattern for the write step
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      cell_mode[i] = CELL_HOLD;
      if (state_r == ST_WRITE && wr_r) begin
        unique case (act_r)
          ACT_PUSH: cell_mode[i] = CELL_DOWN;
          ACT_SWAP: cell_mode[i] = (i < 2) ? CELL_DOWN : CELL_HOLD;
          default:  cell_mode[i] = (i == 0) ? CELL_DOWN : CELL_UP;
        endcase
      end
    end
  end

  // remainder unit, dividend is the second entry
  sae_rem_div u_rem_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (cell_q[1]),
    .divisor_i  (cell_q[0]),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // combinational results: add, sub, swap and mul use the top two cells, others pass the push value
  assign product = cell_q[1] * cell_q[0];

  always_comb begin
    unique case (act_r)
      ACT_PUSH: alu_res = val_r;
      ACT_ADD:  alu_res = cell_q[1] + cell_q[0];
      ACT_SUB:  alu_res = cell_q[1] - cell_q[0];
      ACT_SWAP: alu_res = cell_q[1];
      ACT_MUL:  alu_res = product[DATA_W-1:0];
      default:  alu_res = val_r;
    endcase
  end

  // error check on the current stack
  always_comb begin
    err_nxt = ERR_OK;
    wr_nxt  = 1'b0;
    unique case (act_r)
      ACT_PUSH: begin
        if (count_r == FULL_CNT) err_nxt = ERR_FULL;
        else wr_nxt = 1'b1;
      end
      ACT_ADD, ACT_SUB, ACT_SWAP, ACT_MUL, ACT_MOD: begin
        if (count_r < CNT_W'(2)) err_nxt = ERR_SHORT;
        else if (act_r == ACT_MOD && cell_q[0] == '0) err_nxt = ERR_DIVZERO;
        else wr_nxt = 1'b1;
      end
      default: begin
        err_nxt = ERR_OK;
        wr_nxt  = 1'b0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (wr_nxt && act_r == ACT_MOD) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_WRITE;
      end
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // request capture and result staging
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      act_r <= in_action;
      val_r <= in_push_value;
    end
    if (state_r == ST_EXEC) begin
      res_r <= alu_res;
      err_r <= err_nxt;
      wr_r  <= wr_nxt;
    end
    if (state_r == ST_DIV && div_done) begin
      res_r <= div_rem;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (state_r == ST_WRITE && wr_r) begin
      unique case (act_r)
        ACT_PUSH: count_r <= count_r + 1'b1;
        ACT_SWAP: count_r <= count_r;
        default:  count_r <= count_r - 1'b1;
      endcase
    end
  end

  // output register
  assign count_ext = {{DEPTH_OUT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_top_r   <= (count_r != '0) ? cell_q[0] : '0;
      out_depth_r <= count_ext[DEPTH_OUT_W-1:0];
      out_err_r   <= err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_stack_depth = out_depth_r;
  assign out_error_code  = out_err_r;

endmodule

[hw/rtl/sae_checker.sv]
`include "assert_macros.svh"

module sae_checker
  import sae_pkg::*;
#(
  parameter int STACK_DEPTH = SAE_STACK_DEPTH
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [ACT_W-1:0]         in_action,
  input logic signed [DATA_W-1:0] in_push_value,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_top_value,
  input logic [DEPTH_OUT_W-1:0]   out_stack_depth,
  input logic [1:0]               out_error_code
);

  localparam logic [DEPTH_OUT_W-1:0] FULL_LOW = DEPTH_OUT_W'(STACK_DEPTH);
  localparam logic SMALL_STACK = (STACK_DEPTH < (1 << DEPTH_OUT_W));

  // a stalled result holds
  `SAE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_top_value), "result changed while stalled")

  // a full-stack refusal reports the full depth
  `SAE_ASSERT_IMPL(a_full_depth, out_valid && out_error_code == ERR_FULL, out_stack_depth == FULL_LOW, "full error with wrong depth")

  // too-short error only with fewer than two entries
  `SAE_ASSERT_IMPL(a_short_depth, out_valid && out_error_code == ERR_SHORT, out_stack_depth < 2, "short error with deep stack")

  // a zero divisor stays on top
  `SAE_ASSERT_IMPL(a_divzero_top, out_valid && out_error_code == ERR_DIVZERO, out_top_value == 0, "divide by zero with nonzero top")

  // an empty stack shows zero on top
  `SAE_ASSERT_IMPL(a_empty_top, SMALL_STACK && out_valid && out_stack_depth == 0, out_top_value == 0, "empty stack with nonzero top")

endmodule

bind stack_alu_engine_top sae_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sae_checker (.*);

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sae_pkg::*;

  // codes outside the operation set, which the block treats as no-ops
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam logic [DATA_W-1:0] VAL_MAX    = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_ZERO   = 32'h0000_0000;
  localparam logic [DATA_W-1:0] VAL_ONE    = 32'h0000_0001;
  localparam logic [DATA_W-1:0] VAL_NEG1   = 32'hffff_ffff;
  localparam logic [DATA_W-1:0] VAL_NEG500 = -32'sd500;

  localparam int RANDOM_REQS  = 1250;
  localparam int SETTLE_TICKS = 60;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_PRINTS   = 50;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [DATA_W-1:0] val;
  } stack_req_t;

  typedef struct {
    logic [DATA_W-1:0]      top;
    logic [DEPTH_OUT_W-1:0] depth;
    err_t                   err;
  } stack_view_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ACT_W-1:0]       in_action = '0;
  logic signed [DATA_W-1:0] in_push_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_top_value;
  logic [DEPTH_OUT_W-1:0] out_stack_depth;
  logic [1:0]             out_error_code;

  stack_req_t  req_queue[$];
  stack_view_t view_queue[$];

  // shadow of the operand stack
  logic [DATA_W-1:0] shadow_cells [SAE_STACK_DEPTH];
  int shadow_depth = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit req_taken = 1'b0;
  stack_req_t next_req;

  int cycle_count = 0;
  int reqs_accepted = 0;
  int views_checked = 0;
  int mismatch_count = 0;
  int err_tally [4] = '{0, 0, 0, 0};
  int deepest = 0;
  int gen_depth = 0;
  int gen_count = 0;

  stack_alu_engine_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_top_value  (out_top_value),
    .out_stack_depth(out_stack_depth),
    .out_error_code (out_error_code)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // apply one request to the shadow stack and queue the view it leaves
  function automatic void apply_stack_op(input logic [ACT_W-1:0] act,
                                         input logic [DATA_W-1:0] val);
    stack_view_t view;
    logic [DATA_W-1:0] upper, lower, res, mag_l, mag_r, rem;
    err_t err;
    bit pop;
    err = ERR_OK;
    pop = 1'b0;
    res = '0;
    if (act == ACT_PUSH) begin
      if (shadow_depth >= SAE_STACK_DEPTH) begin
        err = ERR_FULL;
      end else begin
        shadow_cells[shadow_depth] = val;
        shadow_depth++;
      end
    end else if (act <= ACT_MOD) begin
      if (shadow_depth < 2) begin
        err = ERR_SHORT;
      end else begin
        upper = shadow_cells[shadow_depth-1];
        lower = shadow_cells[shadow_depth-2];
        pop = 1'b1;
        case (act)
          ACT_ADD: res = lower + upper;
          ACT_SUB: res = lower - upper;
          ACT_MUL: res = lower * upper;
          ACT_MOD: begin
            if (upper == '0) begin
              err = ERR_DIVZERO;
              pop = 1'b0;
            end else begin
              // remainder on magnitudes, sign taken from the dividend
              mag_l = lower[DATA_W-1] ? -lower : lower;
              mag_r = upper[DATA_W-1] ? -upper : upper;
              rem = mag_l % mag_r;
              res = lower[DATA_W-1] ? -rem : rem;
            end
          end
          default: begin
            shadow_cells[shadow_depth-1] = lower;
            shadow_cells[shadow_depth-2] = upper;
            pop = 1'b0;
          end
        endcase
        if (pop) begin
          shadow_cells[shadow_depth-2] = res;
          shadow_depth--;
        end
      end
    end
    view.top = (shadow_depth > 0) ? shadow_cells[shadow_depth-1] : '0;
    view.depth = shadow_depth[DEPTH_OUT_W-1:0];
    view.err = err;
    view_queue.push_back(view);
    err_tally[err]++;
    if (shadow_depth > deepest) deepest = shadow_depth;
  endfunction

  // stimulus helpers: gen_depth is only a rough guide for shaping
  task automatic queue_req(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
    stack_req_t r;
    r.act = act;
    r.val = val;
    req_queue.push_back(r);
    if (act == ACT_PUSH) begin
      if (gen_depth < SAE_STACK_DEPTH) gen_depth++;
    end else if (act <= ACT_MOD && act != ACT_SWAP && gen_depth >= 2) begin
      gen_depth--;
    end
    if (act <= ACT_MOD) gen_count++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) begin
      case ($urandom_range(5))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return VAL_ZERO;
        3: return VAL_NEG1;
        4: return VAL_ONE;
        default: return VAL_NEG500;
      endcase
    end else if (sel < 50) begin
      return $urandom_range(40) - 20;
    end
    return $urandom;
  endfunction

  function automatic logic [ACT_W-1:0] pick_operation();
    return ACT_W'(ACT_ADD + $urandom_range(ACT_MOD - ACT_ADD));
  endfunction

  task automatic queue_directed();
    queue_req(ACT_ADD, VAL_MAX);
    queue_req(ACT_SWAP, VAL_MIN);
    queue_req(ACT_PUSH, VAL_MAX);
    queue_req(ACT_MOD, VAL_ZERO);
    queue_req(ACT_PUSH, VAL_ONE);
    queue_req(ACT_ADD, VAL_ZERO);
    queue_req(ACT_PUSH, VAL_NEG1);
    queue_req(ACT_MOD, VAL_ZERO);
    queue_req(ACT_PUSH, VAL_NEG500);
    queue_req(ACT_PUSH, VAL_ZERO);
    queue_req(ACT_MOD, VAL_MAX);
    queue_req(ACT_SWAP, VAL_ZERO);
    queue_req(ACT_PUSH, 32'd3);
    queue_req(ACT_MOD, VAL_ZERO);
    queue_req(ACT_PUSH, VAL_MIN);
    queue_req(ACT_SUB, VAL_ZERO);
    queue_req(ACT_PUSH, VAL_MAX);
    queue_req(ACT_MUL, VAL_ZERO);
    queue_req(ACT_PUSH, VAL_NEG1);
    queue_req(ACT_MUL, VAL_ZERO);
    queue_req(ACT_SPARE_LO, VAL_MAX);
    queue_req(ACT_SPARE_HI, VAL_NEG1);
    queue_req(ACT_SUB, VAL_ZERO);
    queue_req(ACT_ADD, VAL_ZERO);
  endtask

  task automatic queue_scenario();
    int kind, n;
    kind = $urandom_range(99);
    if (kind < 50) begin
      // short expression: a few loads then a few operations
      n = $urandom_range(4, 1);
      repeat (n) queue_req(ACT_PUSH, pick_value());
      n = $urandom_range(4, 1);
      repeat (n) queue_req(pick_operation(), pick_value());
    end else if (kind < 62) begin
      // fill to the top and push past it
      while (gen_depth < SAE_STACK_DEPTH) queue_req(ACT_PUSH, pick_value());
      n = $urandom_range(3, 1);
      repeat (n) queue_req(ACT_PUSH, pick_value());
    end else if (kind < 77) begin
      // drain down and run past the bottom
      while (gen_depth >= 2) queue_req(pick_operation(), pick_value());
      n = $urandom_range(2, 1);
      repeat (n) queue_req(pick_operation(), pick_value());
    end else if (kind < 90) begin
      // remainder corner cases
      case ($urandom_range(2))
        0: begin
          queue_req(ACT_PUSH, VAL_MIN);
          queue_req(ACT_PUSH, VAL_NEG1);
        end
        1: begin
          queue_req(ACT_PUSH, pick_value());
          queue_req(ACT_PUSH, VAL_ZERO);
        end
        default: begin
          queue_req(ACT_PUSH, $urandom | VAL_MIN);
          queue_req(ACT_PUSH, $urandom_range(40) - 20);
        end
      endcase
      queue_req(ACT_MOD, pick_value());
    end else begin
      // noise over the full code space
      n = $urandom_range(6, 1);
      repeat (n) queue_req(ACT_W'($urandom_range(7)), pick_value());
    end
  endtask

  // request driver and result ready, both on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = req_queue.pop_front();
        in_valid <= 1'b1;
        in_action <= next_req.act;
        in_push_value <= next_req.val;
      end else begin
        in_valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: check results first, then predict from the accepted request
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (view_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result top=%0d depth=%0d err=%0d",
                                  out_top_value, out_stack_depth, out_error_code));
      end else begin
        if (out_top_value !== view_queue[0].top) begin
          report_mismatch($sformatf("top_value got %0d want %0d",
                                    out_top_value, $signed(view_queue[0].top)));
        end
        if (out_stack_depth !== view_queue[0].depth) begin
          report_mismatch($sformatf("stack_depth got %0d want %0d",
                                    out_stack_depth, view_queue[0].depth));
        end
        if (out_error_code !== view_queue[0].err) begin
          report_mismatch($sformatf("error_code got %0d want %0d",
                                    out_error_code, view_queue[0].err));
        end
        void'(view_queue.pop_front());
        views_checked++;
      end
    end
    if (rst_n && in_valid && in_ready) begin
      apply_stack_op(in_action, in_push_value);
      req_taken = 1'b1;
      reqs_accepted++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, view_queue.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // reset, then three phases of traffic
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 35;
          recv_stall_pct = 55;
          queue_directed();
        end
        1: begin
          send_idle_pct = 55;
          recv_stall_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (gen_count < (phase + 1) * RANDOM_REQS / 3) queue_scenario();
      wait (req_queue.size() == 0 && !in_valid);
      wait (view_queue.size() == 0);
    end
    repeat (SETTLE_TICKS) @(posedge clk);
    if (view_queue.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", view_queue.size()));
    end
    $display("%0d requests accepted, %0d results checked, deepest stack %0d",
             reqs_accepted, views_checked, deepest);
    $display("outcomes: ok %0d, too short %0d, divide by zero %0d, full %0d",
             err_tally[ERR_OK], err_tally[ERR_SHORT], err_tally[ERR_DIVZERO],
             err_tally[ERR_FULL]);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/sae_pkg.sv
hw/rtl/sae_cell.sv
hw/rtl/sae_rem_div.sv
hw/rtl/stack_alu_engine_top.sv
hw/rtl/sae_checker.sv
dv/tb.sv
